// ----- design/powe_pkg.sv -----
package powe_pkg;

    localparam int MaxEntriesDefault = 16;
    localparam logic [14:0] RootWidthReset = 15'd1920;
    localparam logic [14:0] RootHeightReset = 15'd1080;
    localparam logic [14:0] MinVisibleReset = 15'd50;
    localparam logic [14:0] MinAreaReset = 15'd100;

    localparam logic [2:0] REQ_LOAD = 3'd0;
    localparam logic [2:0] REQ_STRUT = 3'd1;
    localparam logic [2:0] REQ_APPLY = 3'd2;
    localparam logic [2:0] REQ_CLAMP = 3'd3;
    localparam logic [2:0] REQ_POINT = 3'd4;

    localparam logic [2:0] CFG_ROOT_W = 3'd0;
    localparam logic [2:0] CFG_ROOT_H = 3'd1;
    localparam logic [2:0] CFG_COUNT = 3'd2;
    localparam logic [2:0] CFG_MIN_VIS = 3'd3;
    localparam logic [2:0] CFG_MIN_AREA = 3'd4;

    localparam logic [1:0] EDGE_LEFT = 2'd0;
    localparam logic [1:0] EDGE_RIGHT = 2'd1;
    localparam logic [1:0] EDGE_TOP = 2'd2;

    // One stored rectangle: 16-bit signed origin, 15-bit size.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
    } rect_t;

    // Work area as stored after an apply.
    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } area_t;

    // Cuts never exceed the output size, and are never negative.
    typedef struct packed {
        logic [14:0] top;
        logic [14:0] bot;
        logic [14:0] left;
        logic [14:0] right;
    } cut_t;

endpackage

// ----- design/per_output_workarea_engine.sv -----
// Per-output work-area engine.
// Items arrive on the req channel (valid/ready); each gives exactly one
// result item on the rsp channel (valid/ready). Configuration registers are
// written through the cfg channel (index, data) while the block is idle; a
// register write that is offered takes precedence and holds req_ready low.
// A load, a strut of zero thickness and the primary query do not walk the
// table. A strut or an apply walks every output in use, each with a read, a
// wait and a compute-and-write step. Point items search for the output under
// the point, one entry at a time, and stop at the first hit; clamp items add
// clamp arithmetic after the search. Walks are paced by the single registered
// read port of the entry table, through which every entry passes in turn.
// The block takes one item at a time: req_ready is low from acceptance
// until the result has been handed over. If the receiver stalls, the result
// is held in the output registers and the block waits.
// Reset clears the sequencer, the registers to their documented values, the
// primary entry and the cuts; rectangles and areas stay undefined until
// loaded.
module per_output_workarea_engine #(
    parameter int MAX_ENTRIES = powe_pkg::MaxEntriesDefault,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  logic [2:0] req_type,
    input  logic [3:0] entry_index,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [14:0] size_w,
    input  logic [14:0] size_h,
    input  logic is_primary,
    input  logic [1:0] edge_req,
    input  logic [14:0] thickness,
    input  logic signed [31:0] span_start,
    input  logic signed [31:0] span_end,
    output logic rsp_valid,
    input  logic rsp_ready,
    output logic signed [16:0] new_x,
    output logic signed [16:0] new_y,
    output logic signed [16:0] area_x,
    output logic signed [16:0] area_y,
    output logic signed [15:0] area_w,
    output logic signed [15:0] area_h,
    output logic [3:0] hit_index,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [14:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_WORK, S_FIND, S_SEL, S_SELW,
        S_CL1, S_CL2, S_CL3, S_DONE
    } state_t;

    state_t state_reg;
    logic [14:0] root_w_reg, root_h_reg, min_vis_reg, min_area_reg;
    logic [4:0] count_reg;
    logic [3:0] primary_reg;
    logic [2:0] type_reg;
    logic [3:0] eidx_reg;
    logic signed [15:0] px_reg, py_reg;
    logic [14:0] w_reg, h_reg, t_reg;
    logic isp_reg;
    logic [1:0] edge_reg;
    logic signed [31:0] s0_reg, s1_reg;
    logic [CW-1:0] k_reg;
    logic [IW-1:0] sel_reg;
    logic found_reg;
    logic signed [17:0] qx_reg, qy_reg;
    logic signed [18:0] nx_reg, ny_reg;

    logic [CW-1:0] n_use;
    logic [IW-1:0] prim;
    logic [IW-1:0] rd_idx;
    powe_pkg::rect_t rd_rect_raw, rd_rect;
    powe_pkg::area_t rd_area;
    powe_pkg::cut_t rd_cut;
    logic rect_we, area_we, cut_we;
    powe_pkg::rect_t rect_wd;
    powe_pkg::area_t area_wd;
    powe_pkg::cut_t cut_wd;
    logic [IW-1:0] wr_idx;
    logic last_k;

    function automatic logic entry_fit(input logic [3:0] i);
        entry_fit = (32'(i) < MAX_ENTRIES);
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
        if (v > 19'sd65535)
        begin
            sat17 = 17'sd65535;
        end
        else if (v < -19'sd65536)
        begin
            sat17 = -17'sd65536;
        end
        else
        begin
            sat17 = v[16:0];
        end
    endfunction

    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (count_reg == 5'd0)
        begin
            n_use = CW'(1);
        end
        else if (32'(count_reg) > MAX_ENTRIES)
        begin
            n_use = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_use = CW'(count_reg);
        end
        if (count_reg == 5'd0 || 32'(primary_reg) >= 32'(n_use))
        begin
            prim = '0;
        end
        else
        begin
            prim = IW'(primary_reg);
        end
    end

    assign last_k = (k_reg + CW'(1) >= n_use);

    // While no outputs are declared, entry 0 is the whole root.
    always_comb
    begin
        rd_rect = rd_rect_raw;
        if (count_reg == 5'd0)
        begin
            rd_rect.x = '0;
            rd_rect.y = '0;
            rd_rect.w = root_w_reg;
            rd_rect.h = root_h_reg;
        end
    end

    // The walk reads the entry under the counter; from selection onwards the
    // selected entry is read and held for the clamp and the result.
    always_comb
    begin
        rd_idx = sel_reg;
        if (state_reg inside {S_READ, S_WAIT, S_WORK, S_FIND})
        begin
            rd_idx = k_reg[IW-1:0];
        end
    end

    powe_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
        .clk(clk), .rst_n(rst_n), .rd_idx(rd_idx),
        .rd_rect(rd_rect_raw), .rd_area(rd_area), .rd_cut(rd_cut),
        .rect_we(rect_we), .rect_idx(wr_idx), .rect_wd(rect_wd),
        .area_we(area_we), .area_idx(wr_idx), .area_wd(area_wd),
        .cut_we(cut_we), .cut_idx(wr_idx), .cut_wd(cut_wd)
    );

    // Per-entry arithmetic for the current walk step.
    logic signed [17:0] o_x0, o_x1, o_y0, o_y1, a0, a1;
    logic signed [32:0] cut_raw;
    logic signed [15:0] cap;
    logic [14:0] cut_clip, acc;
    logic overlap, hit;
    logic signed [17:0] aw_t, ah_t;
    logic signed [16:0] fl;

    always_comb
    begin
        o_x0 = 18'(rd_rect.x);
        o_y0 = 18'(rd_rect.y);
        o_x1 = o_x0 + 18'(rd_rect.w);
        o_y1 = o_y0 + 18'(rd_rect.h);
        if (edge_reg == powe_pkg::EDGE_LEFT || edge_reg == powe_pkg::EDGE_RIGHT)
        begin
            a0 = o_y0;
            a1 = o_y1 - 18'sd1;
            cap = 16'(rd_rect.w);
        end
        else
        begin
            a0 = o_x0;
            a1 = o_x1 - 18'sd1;
            cap = 16'(rd_rect.h);
        end
        overlap = (s0_reg <= 32'(a1)) && (32'(a0) <= s1_reg);
        case (edge_reg)
            powe_pkg::EDGE_LEFT:
            begin
                cut_raw = 33'(t_reg) - 33'(o_x0);
                acc = rd_cut.left;
            end
            powe_pkg::EDGE_RIGHT:
            begin
                cut_raw = 33'(o_x1) - 33'(root_w_reg) + 33'(t_reg);
                acc = rd_cut.right;
            end
            powe_pkg::EDGE_TOP:
            begin
                cut_raw = 33'(t_reg) - 33'(o_y0);
                acc = rd_cut.top;
            end
            default:
            begin
                cut_raw = 33'(o_y1) - 33'(root_h_reg) + 33'(t_reg);
                acc = rd_cut.bot;
            end
        endcase
        if (cut_raw > 33'(cap))
        begin
            cut_clip = cap[14:0];
        end
        else if (cut_raw < 33'sd0)
        begin
            cut_clip = '0;
        end
        else
        begin
            cut_clip = cut_raw[14:0];
        end
        hit = (qx_reg >= o_x0) && (qx_reg < o_x1) && (qy_reg >= o_y0) && (qy_reg < o_y1);
        fl = 17'(min_area_reg);
        aw_t = 18'(rd_rect.w) - 18'(rd_cut.left) - 18'(rd_cut.right);
        ah_t = 18'(rd_rect.h) - 18'(rd_cut.top) - 18'(rd_cut.bot);
    end

    always_comb
    begin
        rect_we = 1'b0;
        area_we = 1'b0;
        cut_we = 1'b0;
        wr_idx = IW'(eidx_reg);
        rect_wd.x = px_reg;
        rect_wd.y = py_reg;
        rect_wd.w = w_reg;
        rect_wd.h = h_reg;
        area_wd.x = 17'(px_reg);
        area_wd.y = 17'(py_reg);
        area_wd.w = 16'(w_reg);
        area_wd.h = 16'(h_reg);
        cut_wd = rd_cut;
        if (state_reg == S_WORK && type_reg == powe_pkg::REQ_LOAD)
        begin
            rect_we = 1'b1;
            area_we = 1'b1;
            cut_we = 1'b1;
            cut_wd = '0;
        end
        else if (state_reg == S_WORK && type_reg == powe_pkg::REQ_STRUT)
        begin
            wr_idx = k_reg[IW-1:0];
            cut_we = overlap && (cut_clip > acc);
            case (edge_reg)
                powe_pkg::EDGE_LEFT: cut_wd.left = cut_clip;
                powe_pkg::EDGE_RIGHT: cut_wd.right = cut_clip;
                powe_pkg::EDGE_TOP: cut_wd.top = cut_clip;
                default: cut_wd.bot = cut_clip;
            endcase
        end
        else if (state_reg == S_WORK && type_reg == powe_pkg::REQ_APPLY)
        begin
            wr_idx = k_reg[IW-1:0];
            area_we = 1'b1;
            area_wd.x = 17'(rd_rect.x) + 17'(rd_cut.left);
            area_wd.y = 17'(rd_rect.y) + 17'(rd_cut.top);
            area_wd.w = (aw_t < 18'(fl)) ? 16'(fl) : aw_t[15:0];
            area_wd.h = (ah_t < 18'(fl)) ? 16'(fl) : ah_t[15:0];
        end
    end

    logic signed [18:0] ax, ay, aw, ah, hh, ww, mv;
    assign ax = 19'(rd_area.x);
    assign ay = 19'(rd_area.y);
    assign aw = 19'(rd_area.w);
    assign ah = 19'(rd_area.h);
    assign hh = 19'(h_reg);
    assign ww = 19'(w_reg);
    assign mv = 19'(min_vis_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_w_reg <= powe_pkg::RootWidthReset;
            root_h_reg <= powe_pkg::RootHeightReset;
            count_reg <= '0;
            min_vis_reg <= powe_pkg::MinVisibleReset;
            min_area_reg <= powe_pkg::MinAreaReset;
            primary_reg <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            powe_pkg::CFG_ROOT_W: root_w_reg <= cfg_data;
                            powe_pkg::CFG_ROOT_H: root_h_reg <= cfg_data;
                            powe_pkg::CFG_COUNT: count_reg <= cfg_data[4:0];
                            powe_pkg::CFG_MIN_VIS: min_vis_reg <= cfg_data;
                            powe_pkg::CFG_MIN_AREA: min_area_reg <= cfg_data;
                            default: ;
                        endcase
                    end
                    else if (req_valid)
                    begin
                        type_reg <= req_type;
                        eidx_reg <= entry_index;
                        px_reg <= pos_x;
                        py_reg <= pos_y;
                        w_reg <= size_w;
                        h_reg <= size_h;
                        isp_reg <= is_primary;
                        edge_reg <= edge_req;
                        t_reg <= thickness;
                        s0_reg <= span_start;
                        s1_reg <= span_end;
                        k_reg <= '0;
                        found_reg <= 1'b0;
                        nx_reg <= 19'(pos_x);
                        ny_reg <= 19'(pos_y);
                        if (req_type == powe_pkg::REQ_CLAMP)
                        begin
                            qx_reg <= 18'(pos_x) + 18'(size_w >> 1);
                            qy_reg <= 18'(pos_y) + 18'(size_h >> 1);
                        end
                        else
                        begin
                            qx_reg <= 18'(pos_x);
                            qy_reg <= 18'(pos_y);
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (type_reg == powe_pkg::REQ_LOAD)
                    begin
                        state_reg <= (32'(entry_fit(eidx_reg)) != 0) ? S_WORK : S_SEL;
                    end
                    else if (type_reg == powe_pkg::REQ_STRUT && t_reg == '0)
                    begin
                        state_reg <= S_SEL;
                    end
                    else if (type_reg == powe_pkg::REQ_STRUT
                             || type_reg == powe_pkg::REQ_APPLY
                             || type_reg == powe_pkg::REQ_CLAMP
                             || type_reg == powe_pkg::REQ_POINT)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_SEL;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= (type_reg == powe_pkg::REQ_CLAMP
                                  || type_reg == powe_pkg::REQ_POINT) ? S_FIND : S_WORK;
                end
                S_FIND:
                begin
                    if (hit)
                    begin
                        sel_reg <= k_reg[IW-1:0];
                        found_reg <= 1'b1;
                        state_reg <= S_SEL;
                    end
                    else if (last_k)
                    begin
                        state_reg <= S_SEL;
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                        state_reg <= S_WAIT;
                    end
                end
                S_WORK:
                begin
                    if (type_reg == powe_pkg::REQ_LOAD)
                    begin
                        if (isp_reg)
                        begin
                            primary_reg <= eidx_reg;
                        end
                        else if (primary_reg == eidx_reg)
                        begin
                            primary_reg <= '0;
                        end
                        state_reg <= S_SEL;
                    end
                    else if (last_k)
                    begin
                        state_reg <= S_SEL;
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                        state_reg <= S_READ;
                    end
                end
                S_SEL:
                begin
                    if (!found_reg)
                    begin
                        sel_reg <= prim;
                    end
                    state_reg <= S_SELW;
                end
                S_SELW:
                begin
                    state_reg <= (type_reg == powe_pkg::REQ_CLAMP) ? S_CL1 : S_CL3;
                end
                S_CL1:
                begin
                    if (ny_reg < ay)
                    begin
                        ny_reg <= ay;
                    end
                    state_reg <= S_CL2;
                end
                S_CL2:
                begin
                    if (ny_reg + hh > ay + ah)
                    begin
                        ny_reg <= (ay + ah - hh < ay) ? ay : ay + ah - hh;
                    end
                    if (nx_reg + mv > ax + aw)
                    begin
                        nx_reg <= ax + aw - mv;
                    end
                    state_reg <= S_CL3;
                end
                S_CL3:
                begin
                    if (type_reg == powe_pkg::REQ_CLAMP && nx_reg + ww - mv < ax)
                    begin
                        nx_reg <= ax - ww + mv;
                    end
                    state_reg <= S_DONE;
                    rsp_valid <= 1'b0;
                end
                S_DONE:
                begin
                    if (!rsp_valid)
                    begin
                        rsp_valid <= 1'b1;
                        new_x <= sat17(nx_reg);
                        new_y <= sat17(ny_reg);
                        area_x <= rd_area.x;
                        area_y <= rd_area.y;
                        area_w <= rd_area.w;
                        area_h <= rd_area.h;
                        hit_index <= 4'(sel_reg);
                    end
                    else if (rsp_ready)
                    begin
                        rsp_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid) else $error("ready while a result is pending");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
    a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid) else $error("result repeated");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WORK && type_reg != powe_pkg::REQ_LOAD |-> k_reg < n_use)
        else $error("walk past entries in use");

endmodule

// ----- design/powe_table.sv -----
// Per-entry store: output rectangles, work areas and edge cuts. One read port
// addressed by the sequencer, one write port each.
module powe_table #(
    parameter int MAX_ENTRIES = powe_pkg::MaxEntriesDefault,
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [IW-1:0] rd_idx,
    output powe_pkg::rect_t rd_rect,
    output powe_pkg::area_t rd_area,
    output powe_pkg::cut_t rd_cut,
    input  logic rect_we,
    input  logic [IW-1:0] rect_idx,
    input  powe_pkg::rect_t rect_wd,
    input  logic area_we,
    input  logic [IW-1:0] area_idx,
    input  powe_pkg::area_t area_wd,
    input  logic cut_we,
    input  logic [IW-1:0] cut_idx,
    input  powe_pkg::cut_t cut_wd
);

    powe_pkg::rect_t rect_mem [MAX_ENTRIES];
    powe_pkg::area_t area_mem [MAX_ENTRIES];
    powe_pkg::cut_t cut_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cut_valid_reg;

    always_ff @(posedge clk)
    begin
        if (rect_we)
        begin
            rect_mem[rect_idx] <= rect_wd;
        end
        if (area_we)
        begin
            area_mem[area_idx] <= area_wd;
        end
        if (cut_we)
        begin
            cut_mem[cut_idx] <= cut_wd;
        end
        rd_rect <= rect_mem[rd_idx];
        rd_area <= area_mem[rd_idx];
        rd_cut <= cut_valid_reg[rd_idx] ? cut_mem[rd_idx] : '0;
    end

    // Cuts reset to zero: a valid bit per entry stands in for a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_valid_reg <= '0;
        end
        else if (cut_we)
        begin
            cut_valid_reg[cut_idx] <= 1'b1;
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    // Request and edge codes that the package does not name.
    localparam logic [2:0] REQ_PRIMARY = 3'd5;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam logic [1:0] EDGE_BOTTOM = 2'd3;

    localparam int  NUM_ENTRIES = 16;
    localparam int  DRAIN_CYCLES = 3 * NUM_ENTRIES + 16;
    localparam longint FULL_SPAN = 64'sd2147483647;

    // One request item, with every field at the width of its port.
    typedef struct {
        logic [2:0]         kind;
        logic [3:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic               prim;
        logic [1:0]         side;
        logic [14:0]        thick;
        logic signed [31:0] s0;
        logic signed [31:0] s1;
    } req_item_t;

    // One response item.
    typedef struct {
        logic [16:0] nx;
        logic [16:0] ny;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [15:0] aw;
        logic [15:0] ah;
        logic [3:0]  hit;
    } rsp_item_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    logic [2:0] req_type;
    logic [3:0] entry_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0] size_w;
    logic [14:0] size_h;
    logic is_primary;
    logic [1:0] edge_req;
    logic [14:0] thickness;
    logic signed [31:0] span_start;
    logic signed [31:0] span_end;
    logic rsp_valid;
    logic rsp_ready;
    logic signed [16:0] new_x;
    logic signed [16:0] new_y;
    logic signed [16:0] area_x;
    logic signed [16:0] area_y;
    logic signed [15:0] area_w;
    logic signed [15:0] area_h;
    logic [3:0] hit_index;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [14:0] cfg_data;

    per_output_workarea_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .size_w      (size_w),
        .size_h      (size_h),
        .is_primary  (is_primary),
        .edge_req    (edge_req),
        .thickness   (thickness),
        .span_start  (span_start),
        .span_end    (span_end),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .new_x       (new_x),
        .new_y       (new_y),
        .area_x      (area_x),
        .area_y      (area_y),
        .area_w      (area_w),
        .area_h      (area_h),
        .hit_index   (hit_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock with an 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The shadow copy of the block's state. Arithmetic is done in 64 bits,
    // and results are cut down to the port widths only when reported.
    longint out_x [NUM_ENTRIES];
    longint out_y [NUM_ENTRIES];
    longint out_w [NUM_ENTRIES];
    longint out_h [NUM_ENTRIES];
    longint wa_x [NUM_ENTRIES];
    longint wa_y [NUM_ENTRIES];
    longint wa_w [NUM_ENTRIES];
    longint wa_h [NUM_ENTRIES];
    longint cut_top [NUM_ENTRIES];
    longint cut_bot [NUM_ENTRIES];
    longint cut_left [NUM_ENTRIES];
    longint cut_right [NUM_ENTRIES];
    int unsigned shadow_primary;

    longint reg_root_w;
    longint reg_root_h;
    int unsigned reg_count;
    longint reg_min_vis;
    longint reg_min_area;

    rsp_item_t expected_rsp [$];
    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    function automatic int unsigned entries_in_use();
        if (reg_count == 0)
            return 1;
        if (reg_count > NUM_ENTRIES)
            return NUM_ENTRIES;
        return reg_count;
    endfunction

    function automatic int unsigned primary_in_use();
        if (reg_count == 0)
            return 0;
        return (shadow_primary < entries_in_use()) ? shadow_primary : 0;
    endfunction

    // Rectangle of an output, with the synthetic root output when the
    // count is zero.
    function automatic void output_box(input int unsigned k, output longint bx,
                                       output longint by, output longint bw,
                                       output longint bh);
        if (reg_count == 0)
        begin
            bx = 0;
            by = 0;
            bw = reg_root_w;
            bh = reg_root_h;
        end
        else
        begin
            bx = out_x[k];
            by = out_y[k];
            bw = out_w[k];
            bh = out_h[k];
        end
    endfunction

    function automatic int unsigned entry_under(input longint px, input longint py);
        longint bx, by, bw, bh;
        for (int unsigned k = 0; k < entries_in_use(); k++)
        begin
            output_box(k, bx, by, bw, bh);
            if (px >= bx && px < bx + bw && py >= by && py < by + bh)
                return k;
        end
        return primary_in_use();
    endfunction

    function automatic longint sat17(input longint v);
        if (v > 65535)
            return 65535;
        if (v < -65536)
            return -65536;
        return v;
    endfunction

    // Deepens the cuts of every output that the strut's span overlaps.
    function automatic void take_strut(input logic [1:0] side, input longint t,
                                       input longint s0, input longint s1);
        longint bx, by, bw, bh, a0, a1, cut, cap;
        if (t <= 0)
            return;
        for (int unsigned k = 0; k < entries_in_use(); k++)
        begin
            output_box(k, bx, by, bw, bh);
            if (side == powe_pkg::EDGE_LEFT || side == powe_pkg::EDGE_RIGHT)
            begin
                a0 = by;
                a1 = by + bh - 1;
                cap = bw;
            end
            else
            begin
                a0 = bx;
                a1 = bx + bw - 1;
                cap = bh;
            end
            if (s0 <= a1 && a0 <= s1)
            begin
                case (side)
                    powe_pkg::EDGE_LEFT:  cut = t - bx;
                    powe_pkg::EDGE_RIGHT: cut = (bx + bw) - (reg_root_w - t);
                    powe_pkg::EDGE_TOP:   cut = t - by;
                    default:              cut = (by + bh) - (reg_root_h - t);
                endcase
                if (cut > cap)
                    cut = cap;
                case (side)
                    powe_pkg::EDGE_LEFT:  if (cut > cut_left[k]) cut_left[k] = cut;
                    powe_pkg::EDGE_RIGHT: if (cut > cut_right[k]) cut_right[k] = cut;
                    powe_pkg::EDGE_TOP:   if (cut > cut_top[k]) cut_top[k] = cut;
                    default:              if (cut > cut_bot[k]) cut_bot[k] = cut;
                endcase
            end
        end
    endfunction

    function automatic void rebuild_areas();
        longint bx, by, bw, bh;
        for (int unsigned k = 0; k < entries_in_use(); k++)
        begin
            output_box(k, bx, by, bw, bh);
            wa_x[k] = bx + cut_left[k];
            wa_y[k] = by + cut_top[k];
            wa_w[k] = bw - cut_left[k] - cut_right[k];
            wa_h[k] = bh - cut_top[k] - cut_bot[k];
            if (wa_w[k] < reg_min_area)
                wa_w[k] = reg_min_area;
            if (wa_h[k] < reg_min_area)
                wa_h[k] = reg_min_area;
        end
    endfunction

    // Advances the shadow state by one request and gives its response.
    function automatic rsp_item_t predict_response(input req_item_t it);
        rsp_item_t r;
        longint px, py, ww, hh, nx, ny, bottom, right;
        int unsigned sel;
        int unsigned k;
        px = it.x;
        py = it.y;
        ww = it.w;
        hh = it.h;
        nx = px;
        ny = py;
        case (it.kind)
            powe_pkg::REQ_LOAD:
            begin
                k = it.idx;
                out_x[k] = px;
                out_y[k] = py;
                out_w[k] = ww;
                out_h[k] = hh;
                wa_x[k] = px;
                wa_y[k] = py;
                wa_w[k] = ww;
                wa_h[k] = hh;
                cut_top[k] = 0;
                cut_bot[k] = 0;
                cut_left[k] = 0;
                cut_right[k] = 0;
                if (it.prim)
                    shadow_primary = k;
                else if (shadow_primary == k)
                    shadow_primary = 0;
                sel = primary_in_use();
            end
            powe_pkg::REQ_STRUT:
            begin
                take_strut(it.side, longint'(it.thick), it.s0, it.s1);
                sel = primary_in_use();
            end
            powe_pkg::REQ_APPLY:
            begin
                rebuild_areas();
                sel = primary_in_use();
            end
            powe_pkg::REQ_CLAMP:
            begin
                // The window is pulled into the area of the output under
                // its midpoint: top edge first, then the bottom without
                // losing the top, then min_visible pixels on each side.
                sel = entry_under(px + ww / 2, py + hh / 2);
                if (ny < wa_y[sel])
                    ny = wa_y[sel];
                bottom = wa_y[sel] + wa_h[sel];
                if (ny + hh > bottom)
                begin
                    ny = bottom - hh;
                    if (ny < wa_y[sel])
                        ny = wa_y[sel];
                end
                right = wa_x[sel] + wa_w[sel];
                if (nx + reg_min_vis > right)
                    nx = right - reg_min_vis;
                if (nx + ww - reg_min_vis < wa_x[sel])
                    nx = wa_x[sel] - ww + reg_min_vis;
                nx = sat17(nx);
                ny = sat17(ny);
            end
            powe_pkg::REQ_POINT:
                sel = entry_under(px, py);
            default:
                sel = primary_in_use();
        endcase
        r.nx = nx[16:0];
        r.ny = ny[16:0];
        r.ax = wa_x[sel][16:0];
        r.ay = wa_y[sel][16:0];
        r.aw = wa_w[sel][15:0];
        r.ah = wa_h[sel][15:0];
        r.hit = sel[3:0];
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off while hold_cycles runs.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Every response handed over is compared with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_item_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response item with nothing expected");
                fail_count++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (new_x !== e.nx)
                begin
                    $error("new_x expected %0d got %0d", $signed(e.nx), new_x);
                    fail_count++;
                end
                if (new_y !== e.ny)
                begin
                    $error("new_y expected %0d got %0d", $signed(e.ny), new_y);
                    fail_count++;
                end
                if (area_x !== e.ax)
                begin
                    $error("area_x expected %0d got %0d", $signed(e.ax), area_x);
                    fail_count++;
                end
                if (area_y !== e.ay)
                begin
                    $error("area_y expected %0d got %0d", $signed(e.ay), area_y);
                    fail_count++;
                end
                if (area_w !== e.aw)
                begin
                    $error("area_w expected %0d got %0d", $signed(e.aw), area_w);
                    fail_count++;
                end
                if (area_h !== e.ah)
                begin
                    $error("area_h expected %0d got %0d", $signed(e.ah), area_h);
                    fail_count++;
                end
                if (hit_index !== e.hit)
                begin
                    $error("hit_index expected %0d got %0d", e.hit, hit_index);
                    fail_count++;
                end
            end
        end
    end

    // Sends one request item. Valid is left high after acceptance so that
    // back-to-back items keep it up; a random gap lowers it first.
    task automatic send_request(input req_item_t it);
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req_type = it.kind;
        entry_index = it.idx;
        pos_x = it.x;
        pos_y = it.y;
        size_w = it.w;
        size_h = it.h;
        is_primary = it.prim;
        edge_req = it.side;
        thickness = it.thick;
        span_start = it.s0;
        span_end = it.s1;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsp.push_back(predict_response(it));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only once the block has gone quiet.
    task automatic write_register(input logic [2:0] index, input logic [14:0] value);
        wait_drained();
        @(negedge clk);
        cfg_index = index;
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            powe_pkg::CFG_ROOT_W:   reg_root_w = value;
            powe_pkg::CFG_ROOT_H:   reg_root_h = value;
            powe_pkg::CFG_COUNT:    reg_count = value[4:0];
            powe_pkg::CFG_MIN_VIS:  reg_min_vis = value;
            powe_pkg::CFG_MIN_AREA: reg_min_area = value;
            default:                ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic req_item_t blank_request(input logic [2:0] kind);
        req_item_t it;
        it.kind = kind;
        it.idx = '0;
        it.x = '0;
        it.y = '0;
        it.w = '0;
        it.h = '0;
        it.prim = 1'b0;
        it.side = powe_pkg::EDGE_LEFT;
        it.thick = '0;
        it.s0 = '0;
        it.s1 = '0;
        return it;
    endfunction

    task automatic load_output(input int k, input int x, input int y, input int w,
                               input int h, input bit prim);
        req_item_t it;
        it = blank_request(powe_pkg::REQ_LOAD);
        it.idx = k[3:0];
        it.x = x[15:0];
        it.y = y[15:0];
        it.w = w[14:0];
        it.h = h[14:0];
        it.prim = prim;
        send_request(it);
    endtask

    task automatic send_strut(input logic [1:0] side, input int t, input longint s0,
                              input longint s1);
        req_item_t it;
        it = blank_request(powe_pkg::REQ_STRUT);
        it.side = side;
        it.thick = t[14:0];
        it.s0 = s0[31:0];
        it.s1 = s1[31:0];
        send_request(it);
    endtask

    task automatic send_query(input logic [2:0] kind, input int x, input int y,
                              input int w, input int h);
        req_item_t it;
        it = blank_request(kind);
        it.x = x[15:0];
        it.y = y[15:0];
        it.w = w[14:0];
        it.h = h[14:0];
        send_request(it);
    endtask

    // Loads every entry in use, entry 0 first, so that nothing reads an
    // entry that was never written. Outputs are laid side by side.
    task automatic load_layout();
        int n;
        int prim_k;
        n = entries_in_use();
        prim_k = $urandom_range(n - 1);
        for (int k = 0; k < n; k++)
            load_output(k, k * 400 + $urandom_range(0, 40) - 20, $urandom_range(0, 60),
                        $urandom_range(150, 420), $urandom_range(200, 1200), k == prim_k);
    endtask

    // A random request: mostly sensible geometry near the outputs, with a
    // quarter of pure noise over the full width of every field.
    function automatic req_item_t random_request();
        req_item_t it;
        int pick;
        it = blank_request(REQ_PRIMARY);
        if ($urandom_range(99) < 25)
        begin
            it.kind = 3'($urandom());
            it.idx = 4'($urandom());
            it.x = 16'($urandom());
            it.y = 16'($urandom());
            it.w = 15'($urandom());
            it.h = 15'($urandom());
            it.prim = 1'($urandom());
            it.side = 2'($urandom());
            it.thick = 15'($urandom());
            it.s0 = $urandom();
            it.s1 = $urandom();
            return it;
        end
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            it.kind = powe_pkg::REQ_LOAD;
            it.idx = 4'($urandom_range(NUM_ENTRIES - 1));
            it.x = 16'($urandom_range(0, 6400) - 200);
            it.y = 16'($urandom_range(0, 400) - 100);
            it.w = 15'($urandom_range(0, 900));
            it.h = 15'($urandom_range(0, 1400));
            it.prim = 1'($urandom());
        end
        else if (pick < 40)
        begin
            it.kind = powe_pkg::REQ_STRUT;
            it.side = 2'($urandom());
            it.thick = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(1, 600));
            it.s0 = $urandom_range(0, 6400) - 300;
            it.s1 = ($urandom_range(4) == 0) ? 32'sd2147483647
                                             : it.s0 + $urandom_range(0, 800);
        end
        else if (pick < 55)
            it.kind = powe_pkg::REQ_APPLY;
        else if (pick < 75)
        begin
            it.kind = powe_pkg::REQ_CLAMP;
            it.x = 16'($urandom_range(0, 7000) - 400);
            it.y = 16'($urandom_range(0, 1800) - 300);
            it.w = 15'($urandom_range(0, 1200));
            it.h = 15'($urandom_range(0, 1500));
        end
        else if (pick < 92)
        begin
            it.kind = powe_pkg::REQ_POINT;
            it.x = 16'($urandom_range(0, 7000) - 400);
            it.y = 16'($urandom_range(0, 1600) - 200);
        end
        else
            it.kind = 3'($urandom_range(REQ_PRIMARY, REQ_SPARE_7));
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    // Synthetic root output at reset values of the registers.
    task automatic test_synthetic_output();
        load_output(0, 10, 10, 500, 500, 1'b1);
        send_strut(powe_pkg::EDGE_LEFT, 60, 0, FULL_SPAN);
        send_strut(powe_pkg::EDGE_RIGHT, 80, 0, 500);
        send_strut(powe_pkg::EDGE_TOP, 30, -5, 5);
        send_strut(EDGE_BOTTOM, 40, 0, FULL_SPAN);
        send_strut(powe_pkg::EDGE_TOP, 0, 0, FULL_SPAN);
        send_query(REQ_PRIMARY, 0, 0, 0, 0);
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_query(powe_pkg::REQ_POINT, 100, 100, 0, 0);
        send_query(powe_pkg::REQ_POINT, -1, 5000, 0, 0);
        send_query(powe_pkg::REQ_CLAMP, 1900, -50, 300, 200);
        send_query(REQ_SPARE_6, 0, 0, 0, 0);
        send_query(REQ_SPARE_7, 0, 0, 0, 0);
    endtask

    // Three outputs: extremes of the fields, clearing of the primary, and
    // saturation of the clamped position.
    task automatic test_directed_edges();
        write_register(powe_pkg::CFG_COUNT, 15'd3);
        load_output(0, 0, 0, 800, 600, 1'b0);
        load_output(1, 800, 0, 32767, 32767, 1'b1);
        load_output(2, -32768, -32768, 0, 0, 1'b0);
        send_strut(powe_pkg::EDGE_LEFT, 32767, -FULL_SPAN - 1, FULL_SPAN);
        send_strut(EDGE_BOTTOM, 200, 700, 900);
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_query(powe_pkg::REQ_CLAMP, 32767, 32767, 32767, 32767);
        send_query(powe_pkg::REQ_CLAMP, -32768, -32768, 0, 0);
        send_query(powe_pkg::REQ_POINT, 32767, 32767, 0, 0);
        load_output(1, 800, 0, 400, 600, 1'b0);
        send_query(REQ_PRIMARY, 0, 0, 0, 0);
        write_register(powe_pkg::CFG_MIN_AREA, 15'd0);
        send_strut(powe_pkg::EDGE_RIGHT, 32767, 0, FULL_SPAN);
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_query(powe_pkg::REQ_POINT, 10, 10, 0, 0);
        write_register(powe_pkg::CFG_MIN_AREA, 15'd32767);
        write_register(powe_pkg::CFG_MIN_VIS, 15'd32767);
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_query(powe_pkg::REQ_CLAMP, 100, 100, 50, 50);
    endtask

    // A count beyond the table saturates to a full table.
    task automatic test_count_saturation();
        write_register(powe_pkg::CFG_COUNT, 15'd20);
        write_register(powe_pkg::CFG_MIN_AREA, 15'd100);
        write_register(powe_pkg::CFG_MIN_VIS, 15'd50);
        load_layout();
        send_strut(powe_pkg::EDGE_TOP, 25, 0, FULL_SPAN);
        send_request(blank_request(powe_pkg::REQ_APPLY));
        send_query(powe_pkg::REQ_POINT, 15 * 400 + 10, 100, 0, 0);
    endtask

    // Random traffic under one register setting and one idling pattern.
    task automatic test_random_phase(input int rw, input int rh, input int cnt,
                                     input int mv, input int ma, input int idle,
                                     input int stall, input int count);
        write_register(powe_pkg::CFG_ROOT_W, rw[14:0]);
        write_register(powe_pkg::CFG_ROOT_H, rh[14:0]);
        write_register(powe_pkg::CFG_COUNT, cnt[14:0]);
        write_register(powe_pkg::CFG_MIN_VIS, mv[14:0]);
        write_register(powe_pkg::CFG_MIN_AREA, ma[14:0]);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        load_layout();
        run_random(count);
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the block holds its result and its request side stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_cycles = 400;
        run_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = REQ_PRIMARY;
        entry_index = '0;
        pos_x = '0;
        pos_y = '0;
        size_w = '0;
        size_h = '0;
        is_primary = 1'b0;
        edge_req = powe_pkg::EDGE_LEFT;
        thickness = '0;
        span_start = '0;
        span_end = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = powe_pkg::CFG_ROOT_W;
        cfg_data = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        shadow_primary = 0;
        reg_root_w = powe_pkg::RootWidthReset;
        reg_root_h = powe_pkg::RootHeightReset;
        reg_count = 0;
        reg_min_vis = powe_pkg::MinVisibleReset;
        reg_min_area = powe_pkg::MinAreaReset;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            cut_top[k] = 0;
            cut_bot[k] = 0;
            cut_left[k] = 0;
            cut_right[k] = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_synthetic_output();
        test_directed_edges();
        test_count_saturation();
        test_random_phase(1920, 1080, 4, 50, 100, 0, 0, 300);
        test_random_phase(32767, 32767, 16, 0, 0, 45, 0, 300);
        test_random_phase(1, 1, 0, 32767, 32767, 0, 45, 200);
        test_random_phase(6400, 1440, 8, 80, 150, 29, 29, 350);
        test_backpressure();
        test_random_phase(2560, 1600, 1, 20, 60, 29, 29, 250);

        wait_drained();
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

endmodule
